[rtl/hashed_direct_mapped_cache_assert.svh]
// ----------------------------------------------------------------------------
// hashed direct-mapped cache assertion macros
// concurrent assertion shorthands shared by the checker
// ----------------------------------------------------------------------------
`ifndef HASHED_DIRECT_MAPPED_CACHE_ASSERT_SVH
`define HASHED_DIRECT_MAPPED_CACHE_ASSERT_SVH

// same-cycle implication, off while in reset
`define HDMC_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("hdmc assertion failed");

// next-cycle implication, off while in reset
`define HDMC_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("hdmc assertion failed");

// next-cycle consequence of reset itself
`define HDMC_ASSERT_RST(lbl, ck, rs, cons) \
  lbl: assert property (@(posedge ck) (rs) |=> (cons)) \
    else $error("hdmc reset assertion failed");

`endif

[rtl/hdmc_pkg.sv]
// ----------------------------------------------------------------------------
// hdmc_pkg
// shared types, constants and hash step function of the hashed cache
// ----------------------------------------------------------------------------
`default_nettype none

package hdmc_pkg;

  localparam int SLOTS_DEFAULT    = 1024;
  localparam int MASK_W           = 10;
  localparam int SLOT_OUT_W       = 10;
  localparam int KEY_W            = 31;
  localparam int TAG_W            = 32;
  localparam int VALUE_W          = 64;
  localparam int HASH_W           = 32;
  localparam int HASH_STEPS       = 6;
  localparam int QUEUE_DEPTH      = 4;
  localparam int IN_TUSER_W       = 2;
  localparam int IN_TDATA_W       = 128;
  localparam int OUT_TUSER_W      = 1;
  localparam int OUT_TDATA_W      = 112;
  localparam int OUT_PAD_W        = OUT_TDATA_W - TAG_W - VALUE_W - SLOT_OUT_W;

  localparam logic [MASK_W-1:0] INDEX_MASK_RESET = 10'd1023;

  localparam logic [HASH_W-1:0] MIX_C0 = 32'h7ed55d16;
  localparam logic [HASH_W-1:0] MIX_C1 = 32'hc761c23c;
  localparam logic [HASH_W-1:0] MIX_C2 = 32'h165667b1;
  localparam logic [HASH_W-1:0] MIX_C3 = 32'hd3a2646c;
  localparam logic [HASH_W-1:0] MIX_C4 = 32'hfd7046c5;
  localparam logic [HASH_W-1:0] MIX_C5 = 32'hb55a4f09;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_STORE  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic {
    BK_RUN   = 1'b0,
    BK_SWEEP = 1'b1
  } back_state_t;

  typedef struct packed {
    op_t                      op;
    logic [KEY_W-1:0]         key;
    logic signed [TAG_W-1:0]  tag;
    logic [VALUE_W-1:0]       value;
  } item_t;

  // one round of the integer mix, selected by round number
  function automatic logic [HASH_W-1:0] mix_step(input logic [2:0] step,
                                                 input logic [HASH_W-1:0] x);
    logic [HASH_W-1:0] r;
    case (step)
      3'd0: r = (x + MIX_C0) + (x << 12);
      3'd1: r = (x ^ MIX_C1) ^ (x >> 19);
      3'd2: r = (x + MIX_C2) + (x << 5);
      3'd3: r = (x + MIX_C3) ^ (x << 9);
      3'd4: r = (x + MIX_C4) + (x << 3);
      3'd5: r = (x ^ MIX_C5) ^ (x >> 16);
      default: r = x;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/hdmc_queue.sv]
// ----------------------------------------------------------------------------
// hdmc_queue
// short fifo between the hashing front end and the slot back end
// ----------------------------------------------------------------------------
`default_nettype none

module hdmc_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              empty
);
  import hdmc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     store_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = store_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_q[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/hdmc_front.sv]
// ----------------------------------------------------------------------------
// hdmc_front
// input stage: takes words, runs the six-round key hash, picks the slot
// ----------------------------------------------------------------------------
`default_nettype none

module hdmc_front #(
  parameter int SLOTS = hdmc_pkg::SLOTS_DEFAULT,
  parameter int IDX_W = $clog2(SLOTS)
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [hdmc_pkg::IN_TUSER_W-1:0] s_tuser,
  input  wire logic [hdmc_pkg::IN_TDATA_W-1:0] s_tdata,
  input  wire logic                            cfg_wr_en,
  input  wire logic [hdmc_pkg::MASK_W-1:0]     cfg_wr_data,
  input  wire logic                            init_busy,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output logic [IDX_W-1:0]                     q_slot,
  output hdmc_pkg::item_t                      q_item
);
  import hdmc_pkg::*;

  localparam int LAST = HASH_STEPS - 1;

  logic [MASK_W-1:0]     index_mask;
  logic [HASH_STEPS-1:0] fv;
  logic [HASH_W-1:0]     fx    [HASH_STEPS];
  item_t                 fitem [HASH_STEPS];

  item_t             in_item;
  logic              en;
  logic [HASH_W-1:0] mask32;
  logic [IDX_W-1:0]  slot_mask;

  assign in_item.op    = op_t'(s_tuser);
  assign in_item.key   = s_tdata[KEY_W-1:0];
  assign in_item.tag   = s_tdata[KEY_W+TAG_W-1:KEY_W];
  assign in_item.value = s_tdata[KEY_W+TAG_W+VALUE_W-1:KEY_W+TAG_W];

  // whole hash line moves together; it halts only when the queue is full
  assign en       = !fv[LAST] || !q_full;
  assign s_tready = en && !init_busy;
  assign q_push   = fv[LAST] && !q_full;

  assign mask32    = HASH_W'(index_mask);
  assign slot_mask = mask32[IDX_W-1:0] & IDX_W'(SLOTS - 1);
  assign q_slot    = fx[LAST][IDX_W-1:0] & slot_mask;
  assign q_item    = fitem[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      index_mask <= INDEX_MASK_RESET;
      fv         <= '0;
    end else begin
      if (cfg_wr_en) begin
        index_mask <= cfg_wr_data;
      end
      if (en) begin
        fv <= {fv[HASH_STEPS-2:0], s_tvalid && s_tready};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx[0]    <= mix_step(3'd0, {1'b0, in_item.key});
      fitem[0] <= in_item;
      for (int i = 1; i < HASH_STEPS; i++) begin
        fx[i]    <= mix_step(3'(i), fx[i-1]);
        fitem[i] <= fitem[i-1];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/hdmc_back.sv]
// ----------------------------------------------------------------------------
// hdmc_back
// slot stage: reads or writes the slot memory, sweeps it on clear, builds results
// ----------------------------------------------------------------------------
`default_nettype none

module hdmc_back #(
  parameter int SLOTS = hdmc_pkg::SLOTS_DEFAULT,
  parameter int IDX_W = $clog2(SLOTS)
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             q_empty,
  input  wire logic [IDX_W-1:0]                 q_slot,
  input  wire hdmc_pkg::item_t                  q_item,
  output logic                                  q_pop,
  output logic                                  init_busy,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [hdmc_pkg::OUT_TUSER_W-1:0]      m_tuser,
  output logic [hdmc_pkg::OUT_TDATA_W-1:0]      m_tdata
);
  import hdmc_pkg::*;

  typedef struct packed {
    logic                     valid;
    logic [KEY_W-1:0]         key;
    logic signed [TAG_W-1:0]  tag;
    logic [VALUE_W-1:0]       value;
  } entry_t;

  entry_t mem [SLOTS];
  entry_t rd_word;

  back_state_t state;
  back_state_t state_next;
  logic [IDX_W-1:0] sweep_cnt;
  logic             init;

  logic             p1_valid;
  op_t              p1_op;
  logic [KEY_W-1:0] p1_key;
  logic [IDX_W-1:0] p1_slot;

  logic                    out_hit;
  logic signed [TAG_W-1:0] out_tag;
  logic [VALUE_W-1:0]      out_value;
  logic [SLOT_OUT_W-1:0]   out_slot;

  logic             out_free;
  logic             p1_room;
  logic             sweep_last;
  logic             mem_we;
  logic             mem_re;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;

  logic                    res_hit;
  logic signed [TAG_W-1:0] res_tag;
  logic [VALUE_W-1:0]      res_value;
  logic [SLOT_OUT_W-1:0]   res_slot;
  logic [31:0]             p1_slot32;

  assign out_free   = !m_tvalid || m_tready;
  assign p1_room    = !p1_valid || out_free;
  assign sweep_last = (sweep_cnt == IDX_W'(SLOTS - 1));
  assign init_busy  = init;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_RUN: begin
        if (q_pop && q_item.op == OP_CLEAR) begin
          state_next = BK_SWEEP;
        end
      end
      BK_SWEEP: begin
        if (sweep_last) begin
          state_next = BK_RUN;
        end
      end
      default: state_next = BK_RUN;
    endcase
  end

  // state outputs: queue pop and memory port control
  always_comb begin
    q_pop     = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = q_slot;
    mem_wdata = '0;
    case (state)
      BK_RUN: begin
        q_pop           = !q_empty && p1_room;
        mem_re          = q_pop && q_item.op == OP_LOOKUP;
        mem_we          = q_pop && q_item.op == OP_STORE;
        mem_wdata.valid = 1'b1;
        mem_wdata.key   = q_item.key;
        mem_wdata.tag   = q_item.tag;
        mem_wdata.value = q_item.value;
      end
      BK_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_cnt;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_SWEEP;
      sweep_cnt <= '0;
      init      <= 1'b1;
    end else begin
      state <= state_next;
      if (state == BK_SWEEP) begin
        sweep_cnt <= sweep_last ? '0 : sweep_cnt + 1'b1;
        if (sweep_last) begin
          init <= 1'b0;
        end
      end
    end
  end

  // slot memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_word <= mem[q_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (q_pop) begin
        p1_valid <= 1'b1;
      end else if (out_free) begin
        p1_valid <= 1'b0;
      end
      if (out_free) begin
        m_tvalid <= p1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      p1_op   <= q_item.op;
      p1_key  <= q_item.key;
      p1_slot <= q_slot;
    end
    if (out_free && p1_valid) begin
      out_hit   <= res_hit;
      out_tag   <= res_tag;
      out_value <= res_value;
      out_slot  <= res_slot;
    end
  end

  assign p1_slot32 = 32'(p1_slot);

  always_comb begin
    res_hit   = 1'b0;
    res_tag   = '0;
    res_value = '0;
    res_slot  = '0;
    case (p1_op)
      OP_LOOKUP: begin
        res_slot = p1_slot32[SLOT_OUT_W-1:0];
        if (rd_word.valid && rd_word.key == p1_key) begin
          res_hit   = 1'b1;
          res_tag   = rd_word.tag;
          res_value = rd_word.value;
        end
      end
      OP_STORE: begin
        res_slot = p1_slot32[SLOT_OUT_W-1:0];
      end
      default: begin
        res_hit = 1'b0;
      end
    endcase
  end

  assign m_tuser = out_hit;
  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_slot, out_value, out_tag};

endmodule

`default_nettype wire

[rtl/hashed_direct_mapped_cache.sv]
// ----------------------------------------------------------------------------
// hashed_direct_mapped_cache
// direct-mapped key cache with hashed slot selection
// ----------------------------------------------------------------------------
// usage:
//   s_* takes one request word per handshake: op in s_tuser (lookup, store,
//   clear all), key, tag and value in s_tdata. m_* returns exactly one result
//   word per request, in order: hit in m_tuser, found tag, found value and
//   slot index in m_tdata. cfg_wr_en/cfg_wr_data set the index mask while idle.
//   with nothing queued ahead a request passes the six hash rounds, the queue,
//   the slot read and the result register before its result appears.
//   lookups and stores run at one word per cycle while results are taken and
//   no sweep runs, bounded by the single read and write port of the slot memory.
//   a clear sweeps every slot (SLOTS, 1024 by default) before the next
//   request reaches the memory; requests keep filling the queue meanwhile.
//   after reset the same sweep runs with s_tready low.
//   if m_tready stays low the result register holds, the queue fills, and
//   then s_tready drops; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_direct_mapped_cache #(
  parameter int SLOTS = hdmc_pkg::SLOTS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [hdmc_pkg::IN_TUSER_W-1:0]  s_tuser,  // op
  input  wire logic [hdmc_pkg::IN_TDATA_W-1:0]  s_tdata,  // key, entry_tag, entry_value
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [hdmc_pkg::OUT_TUSER_W-1:0]      m_tuser,  // hit
  output logic [hdmc_pkg::OUT_TDATA_W-1:0]      m_tdata,  // found_tag, found_value, slot_index
  input  wire logic                             cfg_wr_en,
  input  wire logic [hdmc_pkg::MASK_W-1:0]      cfg_wr_data
);
  import hdmc_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int Q_W   = IDX_W + $bits(item_t);

  logic             init_busy;
  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  logic [IDX_W-1:0] f_slot;
  item_t            f_item;
  logic [Q_W-1:0]   q_out;
  logic [IDX_W-1:0] b_slot;
  item_t            b_item;

  assign b_slot = q_out[Q_W-1:$bits(item_t)];
  assign b_item = q_out[$bits(item_t)-1:0];

  hdmc_front #(
    .SLOTS(SLOTS),
    .IDX_W(IDX_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tuser     (s_tuser),
    .s_tdata     (s_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .init_busy   (init_busy),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_slot      (f_slot),
    .q_item      (f_item)
  );

  hdmc_queue #(
    .W(Q_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({f_slot, f_item}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  hdmc_back #(
    .SLOTS(SLOTS),
    .IDX_W(IDX_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_slot    (b_slot),
    .q_item    (b_item),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tuser   (m_tuser),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire

[rtl/hdmc_checker.sv]
// ----------------------------------------------------------------------------
// hdmc_checker
// port-level checks of the hashed cache, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "hashed_direct_mapped_cache_assert.svh"

module hdmc_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_tready,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  input wire logic [hdmc_pkg::OUT_TUSER_W-1:0] m_tuser,
  input wire logic [hdmc_pkg::OUT_TDATA_W-1:0] m_tdata
);

  // the slot sweep after reset keeps the input closed
  `HDMC_ASSERT_RST(a_rst_blocks_input, clk, rst, !s_tready)

  // no result can be pending right after reset
  `HDMC_ASSERT_RST(a_rst_empties_output, clk, rst, !m_tvalid)

  // without a hit the found tag and value read as zero
  `HDMC_ASSERT_IMP(a_miss_is_zero, clk, rst, m_tvalid && !m_tuser[0], m_tdata[95:0] == '0)

  // a stalled result holds
  `HDMC_ASSERT_NXT(a_hold_stalled, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind hashed_direct_mapped_cache hdmc_checker u_hdmc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tuser  (m_tuser),
  .m_tdata  (m_tdata)
);

`default_nettype wire
